[rtl/core/pmd_pkg.sv]
// ----------------------------------------------------------------------------
// PID motor drive package
// Request and result types, configuration codes and fixed-point constants
// shared by the PID speed-loop modules.
// ----------------------------------------------------------------------------
package pmd_pkg;

    // Input request: target and measured wheel speed, signed Q8.8.
    typedef struct packed {
        logic signed [15:0] reference;
        logic signed [15:0] measured;
    } t_pmd_in;

    // Result request: PWM drive value and the clamp flag.
    typedef struct packed {
        logic signed [8:0] drive;
        logic              clamped;
    } t_pmd_out;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_P_GAIN = 2'd0,
        CFG_I_GAIN = 2'd1,
        CFG_D_GAIN = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int SUM_W      = 32;
    localparam int PE_W       = 34;
    localparam int IE_W       = 49;
    localparam int DE_W       = 35;
    localparam int TOTAL_W    = 50;
    localparam int MAG_W      = 31;
    localparam int QUO_IN_W   = 15;
    localparam int NUM_STAGES = 7;

    localparam logic [GAIN_W-1:0] P_GAIN_RST = 16'd1536;
    localparam logic [GAIN_W-1:0] I_GAIN_RST = 16'd25600;
    localparam logic [GAIN_W-1:0] D_GAIN_RST = 16'd0;

    // Full-scale total for one drive step is 100 * 65536.
    localparam logic signed [TOTAL_W-1:0] DRIVE_LIMIT = 50'sd1671168000;
    localparam logic [MAG_W-1:0]          HALF_SCALE  = 31'd3276800;
    // floor(y / 100) = (y * 5243) >> 19 for y below 43699.
    localparam logic [12:0]               RECIP_100   = 13'd5243;
    localparam int                        RECIP_SHIFT = 19;

    localparam logic signed [8:0] DRIVE_MAX = 9'sd255;
    localparam logic signed [8:0] DRIVE_MIN = -9'sd255;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

    // Front-end results handed from the integrator to the term pipeline.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  isum;
    } t_pmd_front;

endpackage

[rtl/core/pmd_integrator.sv]
// ----------------------------------------------------------------------------
// PID error and integrator stage
// Forms the error, its difference to the last error and the saturated error
// sum for each accepted request, and keeps the loop state.
// ----------------------------------------------------------------------------
module pmd_integrator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_load,
    input  pmd_pkg::t_pmd_in    i_req,
    output pmd_pkg::t_pmd_front o_front
);

    logic signed [pmd_pkg::SUM_W-1:0] r_error_sum;
    logic signed [pmd_pkg::ERR_W-1:0] r_last_error;
    pmd_pkg::t_pmd_front              r_front;

    logic signed [pmd_pkg::ERR_W-1:0] n_err;
    logic signed [pmd_pkg::SUM_W:0]   n_sum_wide;
    logic signed [pmd_pkg::SUM_W-1:0] n_sum;
    logic                             n_ref_zero;

    // Error, and the integrator sum saturated at the 32-bit limits.
    always_comb begin
        n_err      = pmd_pkg::ERR_W'(i_req.reference) - pmd_pkg::ERR_W'(i_req.measured);
        n_sum_wide = (pmd_pkg::SUM_W+1)'(r_error_sum) + (pmd_pkg::SUM_W+1)'(n_err);
        if (n_sum_wide[pmd_pkg::SUM_W] != n_sum_wide[pmd_pkg::SUM_W-1]) begin
            n_sum = n_sum_wide[pmd_pkg::SUM_W] ? pmd_pkg::SUM_MIN : pmd_pkg::SUM_MAX;
        end else begin
            n_sum = n_sum_wide[pmd_pkg::SUM_W-1:0];
        end
        n_ref_zero = (i_req.reference == '0);
    end

    // Loop state changes only with an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (i_accept) begin
            r_error_sum  <= n_ref_zero ? '0 : n_sum;
            r_last_error <= n_err;
        end
    end

    // Stage register; a zero reference drops the I term for this request.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_front.err  <= n_err;
            r_front.diff <= pmd_pkg::DIFF_W'(n_err) - pmd_pkg::DIFF_W'(r_last_error);
            r_front.isum <= n_ref_zero ? '0 : n_sum;
        end
    end

    assign o_front = r_front;

endmodule

[rtl/core/pid_motor_drive.sv]
// ----------------------------------------------------------------------------
// PID motor drive
// One wheel's PID speed loop: error, saturating integrator, derivative,
// Q8.8 gains, clamp to +-255 and round half away from zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid with i_in_req (reference, measured); the block
//   stalls the sender through o_in_stall. Output channel: o_out_valid with
//   o_out_req (drive, clamped); the receiver holds i_out_stall high to wait.
//   A request is taken on an edge where valid is high and stall is low.
//   One request can be taken every cycle while o_in_stall is low; the
//   seven-stage pipeline (error and integrator, gain multipliers, constant
//   scaling, total, clamp, rounding, divide by 100 via reciprocal) carries
//   each request to o_out_valid, and the integrator update in the first
//   stage lets each request use the state left by the one before.
//   Each stage moves on when the stage after it is empty or moving, so a
//   stalled result only holds the pipeline once every stage is full.
//   Gains are written through i_cfg_we, i_cfg_index and i_cfg_data while the
//   block is idle; unknown indexes are ignored.
//   Reset clears the error sum, the last error, all stage valids and sets
//   the gains to 6.0, 100.0 and 0.0.
// ----------------------------------------------------------------------------
module pid_motor_drive (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pmd_pkg::t_pmd_in                  i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pmd_pkg::t_pmd_out                 o_out_req,
    input  logic                              i_cfg_we,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pmd_pkg::GAIN_W-1:0]        i_cfg_data
);

    localparam int NS = pmd_pkg::NUM_STAGES;

    logic [pmd_pkg::GAIN_W-1:0] r_p_gain;
    logic [pmd_pkg::GAIN_W-1:0] r_i_gain;
    logic [pmd_pkg::GAIN_W-1:0] r_d_gain;

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_en;
    logic          n_accept;

    pmd_pkg::t_pmd_front front;

    logic signed [pmd_pkg::PE_W-1:0]    r2_pe;
    logic signed [pmd_pkg::IE_W-1:0]    r2_ie;
    logic signed [pmd_pkg::DE_W-1:0]    r2_de;
    logic signed [pmd_pkg::TOTAL_W-1:0] r3_p;
    logic signed [pmd_pkg::TOTAL_W-1:0] r3_i;
    logic signed [pmd_pkg::TOTAL_W-1:0] r3_d;
    logic signed [pmd_pkg::TOTAL_W-1:0] r4_total;
    logic [pmd_pkg::MAG_W-1:0]          r5_mag;
    logic                               r5_neg;
    logic                               r5_hi;
    logic                               r5_lo;
    logic [pmd_pkg::QUO_IN_W-1:0]       r6_y;
    logic                               r6_neg;
    logic                               r6_hi;
    logic                               r6_lo;
    pmd_pkg::t_pmd_out                  r_out;

    logic signed [pmd_pkg::TOTAL_W-1:0] n_pe_ext;
    logic signed [pmd_pkg::TOTAL_W-1:0] n_de_ext;
    logic signed [pmd_pkg::TOTAL_W-1:0] n_abs;
    logic [pmd_pkg::MAG_W-1:0]          n_rounded;
    logic [27:0]                        n_quo_prod;
    logic [8:0]                         n_quo;

    // Gain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain <= pmd_pkg::P_GAIN_RST;
            r_i_gain <= pmd_pkg::I_GAIN_RST;
            r_d_gain <= pmd_pkg::D_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pmd_pkg::CFG_P_GAIN: r_p_gain <= i_cfg_data;
                pmd_pkg::CFG_I_GAIN: r_i_gain <= i_cfg_data;
                pmd_pkg::CFG_D_GAIN: r_d_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it is moving.
    always_comb begin
        n_en[NS-1] = !r_v[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_in_stall = !n_en[0];
    assign n_accept   = i_in_valid && n_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: error, difference and integrator.
    pmd_integrator u_integrator (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (n_accept),
        .i_load   (n_en[0]),
        .i_req    (i_in_req),
        .o_front  (front)
    );

    // Stage 2: gain multiplications.
    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r2_pe <= $signed({1'b0, r_p_gain}) * front.err;
            r2_ie <= $signed({1'b0, r_i_gain}) * front.isum;
            r2_de <= $signed({1'b0, r_d_gain}) * front.diff;
        end
    end

    // Stage 3: scale P by 100 and D by 10000 with shifts and adds.
    always_comb begin
        n_pe_ext = pmd_pkg::TOTAL_W'(r2_pe);
        n_de_ext = pmd_pkg::TOTAL_W'(r2_de);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            r3_p <= (n_pe_ext <<< 6) + (n_pe_ext <<< 5) + (n_pe_ext <<< 2);
            r3_d <= (n_de_ext <<< 13) + (n_de_ext <<< 10) + (n_de_ext <<< 9)
                  + (n_de_ext <<< 8) + (n_de_ext <<< 4);
            r3_i <= pmd_pkg::TOTAL_W'(r2_ie);
        end
    end

    // Stage 4: total, scaled by 100 * 65536.
    always_ff @(posedge i_clk) begin
        if (n_en[3]) begin
            r4_total <= r3_p + r3_i + r3_d;
        end
    end

    // Stage 5: clamp detection and magnitude.
    assign n_abs = r4_total[pmd_pkg::TOTAL_W-1] ? -r4_total : r4_total;

    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r5_hi  <= r4_total > pmd_pkg::DRIVE_LIMIT;
            r5_lo  <= r4_total < -pmd_pkg::DRIVE_LIMIT;
            r5_neg <= r4_total[pmd_pkg::TOTAL_W-1];
            r5_mag <= n_abs[pmd_pkg::MAG_W-1:0];
        end
    end

    // Stage 6: add half a step and drop the 65536 scale.
    assign n_rounded = r5_mag + pmd_pkg::HALF_SCALE;

    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r6_y   <= n_rounded[pmd_pkg::MAG_W-1:16];
            r6_neg <= r5_neg;
            r6_hi  <= r5_hi;
            r6_lo  <= r5_lo;
        end
    end

    // Stage 7: divide by 100 through the reciprocal, apply sign or clamp.
    always_comb begin
        n_quo_prod = 28'(r6_y) * 28'(pmd_pkg::RECIP_100);
        n_quo      = {1'b0, n_quo_prod[pmd_pkg::RECIP_SHIFT+7:pmd_pkg::RECIP_SHIFT]};
    end

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            if (r6_hi) begin
                r_out.drive <= pmd_pkg::DRIVE_MAX;
            end else if (r6_lo) begin
                r_out.drive <= pmd_pkg::DRIVE_MIN;
            end else if (r6_neg) begin
                r_out.drive <= -$signed(n_quo);
            end else begin
                r_out.drive <= $signed(n_quo);
            end
            r_out.clamped <= r6_hi || r6_lo;
        end
    end

    assign o_out_valid = r_v[NS-1];
    assign o_out_req   = r_out;

`ifndef SYNTHESIS
    // A clamped result always sits on one of the drive limits.
    a_clamp_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.clamped) |->
        (o_out_req.drive == pmd_pkg::DRIVE_MAX || o_out_req.drive == pmd_pkg::DRIVE_MIN))
        else $error("clamped result not at drive limit");

    // The sender is held off only when every stage is full and the output waits.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // An accepted request occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> r_v[0])
        else $error("accepted request lost at first stage");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// PID motor drive testbench
// Drives speed requests through the PID loop under random idling on both
// channels, and checks each drive result against a typed-in value or a model of
// the loop: error, saturating integrator, derivative, gains, clamp, rounding.
// A short table of directed requests comes first, then an integrator ramp
// through both drive limits, then random requests under several gain settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = pmd_pkg::NUM_STAGES + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 500;
    localparam int MAX_PRINTS     = 40;
    localparam int WINDUP_UP      = 100;
    localparam int WINDUP_DOWN    = 200;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 55;
    localparam int CALM_ITEMS     = 30;
    localparam int DIR_ROWS       = 30;

    // Register index that the block does not decode.
    localparam logic [pmd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Fixed-point scale of the exact total: one drive step is 100 * 65536.
    localparam longint STEP_SCALE = 64'sd6553600;
    localparam longint HALF_STEP  = 64'sd3276800;

    // Requests with the largest error of either sign.
    localparam pmd_pkg::t_pmd_in FULL_FWD = '{reference: 16'sh7FFF, measured: 16'sh8000};
    localparam pmd_pkg::t_pmd_in FULL_REV = '{reference: 16'sh8000, measured: 16'sh7FFF};

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // One line of the directed table: a register write or a request with,
    // where it is obvious, the drive result typed in.
    typedef struct packed {
        t_row_kind                         kind;
        logic [pmd_pkg::CFG_IDX_W-1:0]     idx;
        logic [pmd_pkg::GAIN_W-1:0]        data;
        pmd_pkg::t_pmd_in                  req;
        logic                              known;
        pmd_pkg::t_pmd_out                 res;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // Reset gains (6.0, 100.0, 0.0).
        '{ROW_REQ, '0, '0, '{16'sd0, 16'sd0}, 1'b1, '{9'sd0, 1'b0}},
        '{ROW_REQ, '0, '0, FULL_FWD, 1'b1, '{pmd_pkg::DRIVE_MAX, 1'b1}},
        '{ROW_REQ, '0, '0, FULL_REV, 1'b1, '{pmd_pkg::DRIVE_MIN, 1'b1}},
        '{ROW_REQ, '0, '0, '{16'sd0, 16'sd0}, 1'b1, '{9'sd0, 1'b0}},
        '{ROW_REQ, '0, '0, '{16'sd256, 16'sd0}, 1'b0, '0},
        // Zero reference drops the I term: 6.0 * 2.0.
        '{ROW_REQ, '0, '0, '{16'sd0, -16'sd512}, 1'b1, '{9'sd12, 1'b0}},
        '{ROW_REQ, '0, '0, '{16'sd128, 16'sd0}, 1'b0, '0},
        // A write to an undecoded index must leave every gain alone.
        '{ROW_CFG, CFG_UNUSED, 16'd0, '0, 1'b0, '0},
        '{ROW_REQ, '0, '0, '{16'sd256, 16'sd0}, 1'b0, '0},
        // Unit P gain only: drive is the error in whole units.
        '{ROW_CFG, pmd_pkg::CFG_P_GAIN, 16'd256, '0, 1'b0, '0},
        '{ROW_CFG, pmd_pkg::CFG_I_GAIN, 16'd0, '0, 1'b0, '0},
        '{ROW_CFG, pmd_pkg::CFG_D_GAIN, 16'd0, '0, 1'b0, '0},
        '{ROW_REQ, '0, '0, '{16'sd32640, -16'sd32640}, 1'b1, '{pmd_pkg::DRIVE_MAX, 1'b0}},
        '{ROW_REQ, '0, '0, '{16'sd32641, -16'sd32640}, 1'b1, '{pmd_pkg::DRIVE_MAX, 1'b1}},
        '{ROW_REQ, '0, '0, '{-16'sd32640, 16'sd32640}, 1'b1, '{pmd_pkg::DRIVE_MIN, 1'b0}},
        '{ROW_REQ, '0, '0, '{-16'sd32641, 16'sd32640}, 1'b1, '{pmd_pkg::DRIVE_MIN, 1'b1}},
        '{ROW_REQ, '0, '0, '{16'sd128, 16'sd0}, 1'b1, '{9'sd1, 1'b0}},
        '{ROW_REQ, '0, '0, '{-16'sd128, 16'sd0}, 1'b1, '{-9'sd1, 1'b0}},
        '{ROW_REQ, '0, '0, '{16'sd127, 16'sd0}, 1'b1, '{9'sd0, 1'b0}},
        '{ROW_REQ, '0, '0, '{16'sd0, 16'sd128}, 1'b1, '{-9'sd1, 1'b0}},
        '{ROW_REQ, '0, '0, '{16'sd384, 16'sd0}, 1'b1, '{9'sd2, 1'b0}},
        // Full D gain alone: the change of error here saturates the drive.
        '{ROW_CFG, pmd_pkg::CFG_P_GAIN, 16'd0, '0, 1'b0, '0},
        '{ROW_CFG, pmd_pkg::CFG_D_GAIN, 16'd65535, '0, 1'b0, '0},
        '{ROW_REQ, '0, '0, '{16'sd0, 16'sd0}, 1'b1, '{pmd_pkg::DRIVE_MIN, 1'b1}},
        '{ROW_REQ, '0, '0, '{16'sd0, 16'sd0}, 1'b1, '{9'sd0, 1'b0}},
        // Full I gain alone.
        '{ROW_CFG, pmd_pkg::CFG_D_GAIN, 16'd0, '0, 1'b0, '0},
        '{ROW_CFG, pmd_pkg::CFG_I_GAIN, 16'd65535, '0, 1'b0, '0},
        '{ROW_REQ, '0, '0, '{16'sd1, 16'sd0}, 1'b0, '0},
        '{ROW_REQ, '0, '0, '{16'sh7FFF, 16'sh7FFE}, 1'b0, '0},
        '{ROW_REQ, '0, '0, '{16'sd0, 16'sd0}, 1'b0, '0}
    };

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_stall;
    pmd_pkg::t_pmd_in                in_req      = '0;
    logic                            out_valid;
    logic                            out_stall   = 1'b0;
    pmd_pkg::t_pmd_out               out_req;
    logic                            cfg_we      = 1'b0;
    logic [pmd_pkg::CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [pmd_pkg::GAIN_W-1:0]      cfg_data    = '0;

    // Model state: gains, integrator and previous error.
    logic [pmd_pkg::GAIN_W-1:0]       kp         = pmd_pkg::P_GAIN_RST;
    logic [pmd_pkg::GAIN_W-1:0]       ki         = pmd_pkg::I_GAIN_RST;
    logic [pmd_pkg::GAIN_W-1:0]       kd         = pmd_pkg::D_GAIN_RST;
    logic signed [pmd_pkg::SUM_W-1:0] integ_sum  = '0;
    logic signed [pmd_pkg::ERR_W-1:0] prev_err   = '0;

    pmd_pkg::t_pmd_out drive_queue[$];
    int       fail_count    = 0;
    int       result_count  = 0;
    int       idle_cycles   = 0;
    int       stall_left    = 0;
    int       setpoint      = 256;
    bit       calm          = 1'b0;

    pid_motor_drive u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Prints one line per mismatch, up to a cap, and counts them all.
    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        if (fail_count < MAX_PRINTS) begin
            $display("result %0d: %s mismatch, got %0d, expected %0d",
                     result_count, what, got, want);
        end
        fail_count++;
    endtask

    // Advances the loop state by one request and returns its drive result.
    function automatic pmd_pkg::t_pmd_out compute_drive(pmd_pkg::t_pmd_in req);
        longint            err;
        longint            diff;
        longint            acc;
        longint            total;
        longint            level;
        pmd_pkg::t_pmd_out res;

        err  = longint'($signed(req.reference)) - longint'($signed(req.measured));
        diff = err - longint'(prev_err);
        acc  = longint'(integ_sum) + err;
        if (acc > longint'(pmd_pkg::SUM_MAX)) begin
            acc = longint'(pmd_pkg::SUM_MAX);
        end else if (acc < longint'(pmd_pkg::SUM_MIN)) begin
            acc = longint'(pmd_pkg::SUM_MIN);
        end
        prev_err = err[pmd_pkg::ERR_W-1:0];

        total = 100 * longint'(kp) * err + 10000 * longint'(kd) * diff;
        if (req.reference == '0) begin
            integ_sum = '0;
        end else begin
            integ_sum = acc[pmd_pkg::SUM_W-1:0];
            total     = total + longint'(ki) * acc;
        end

        // Clamp strictly beyond the limits, otherwise round half away from zero.
        res.clamped = 1'b0;
        if (total > longint'(pmd_pkg::DRIVE_MAX) * STEP_SCALE) begin
            res.drive   = pmd_pkg::DRIVE_MAX;
            res.clamped = 1'b1;
        end else if (total < longint'(pmd_pkg::DRIVE_MIN) * STEP_SCALE) begin
            res.drive   = pmd_pkg::DRIVE_MIN;
            res.clamped = 1'b1;
        end else begin
            if (total >= 0) begin
                level = (total + HALF_STEP) / STEP_SCALE;
            end else begin
                level = -((-total + HALF_STEP) / STEP_SCALE);
            end
            res.drive = level[8:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // Random request: mostly a measured speed tracking a held setpoint,
    // with zero references, extremes and raw noise mixed in.
    function automatic pmd_pkg::t_pmd_in random_request();
        pmd_pkg::t_pmd_in req;
        int               meas;

        case ($urandom_range(0, 9))
            0: begin
                req.reference = 16'($urandom);
                req.measured  = 16'($urandom);
            end
            1: begin
                req.reference = '0;
                req.measured  = 16'(int'($urandom_range(0, 1023)) - 512);
            end
            2: begin
                req.reference = extreme_value();
                req.measured  = extreme_value();
            end
            default: begin
                if ($urandom_range(0, 15) == 0) begin
                    setpoint = int'($urandom_range(0, 65535)) - 32768;
                end
                meas = setpoint + int'($urandom_range(0, 800)) - 400;
                if (meas > 32767) begin
                    meas = 32767;
                end else if (meas < -32768) begin
                    meas = -32768;
                end
                req.reference = 16'(setpoint);
                req.measured  = 16'(meas);
            end
        endcase
        return req;
    endfunction

    // Sends one request, with an optional gap first, and records the
    // expected drive result once the block takes it.
    task automatic send_request(pmd_pkg::t_pmd_in req, logic known,
                                pmd_pkg::t_pmd_out fixed);
        pmd_pkg::t_pmd_out want;

        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do begin
            @(posedge clk);
        end while (in_stall);
        want = compute_drive(req);
        if (known) begin
            want = fixed;
        end
        drive_queue.push_back(want);
    endtask

    // Holds off new requests until every expected result has come back.
    task automatic drain_results();
        if (drive_queue.size() != 0) begin
            in_valid <= 1'b0;
            while (drive_queue.size() != 0) begin
                @(posedge clk);
            end
        end
    endtask

    // Gain writes happen only with the pipeline empty.
    task automatic write_gain(logic [pmd_pkg::CFG_IDX_W-1:0] idx,
                              logic [pmd_pkg::GAIN_W-1:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pmd_pkg::CFG_P_GAIN: kp = val;
            pmd_pkg::CFG_I_GAIN: ki = val;
            pmd_pkg::CFG_D_GAIN: kd = val;
            default: ;
        endcase
    endtask

    // Receiver stall in random bursts.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && rst_n && $urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        pmd_pkg::t_pmd_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (drive_queue.size() == 0) begin
                report_mismatch("unexpected result drive", out_req.drive, 0);
            end else begin
                want = drive_queue.pop_front();
                if (out_req.drive !== want.drive) begin
                    report_mismatch("drive", out_req.drive, want.drive);
                end
                if (out_req.clamped !== want.clamped) begin
                    report_mismatch("clamped", out_req.clamped, want.clamped);
                end
            end
            result_count++;
        end
    end

    // Ends the run when neither channel moves for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int guard;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int row = 0; row < DIR_ROWS; row++) begin
            if (DIR_TABLE[row].kind == ROW_CFG) begin
                write_gain(DIR_TABLE[row].idx, DIR_TABLE[row].data);
            end else begin
                send_request(DIR_TABLE[row].req, DIR_TABLE[row].known,
                             DIR_TABLE[row].res);
            end
        end

        // Integrator ramp up past the upper drive limit, then down past the
        // lower one. A unit I gain moves the drive a few steps per request.
        write_gain(pmd_pkg::CFG_P_GAIN, 16'd0);
        write_gain(pmd_pkg::CFG_I_GAIN, 16'd256);
        write_gain(pmd_pkg::CFG_D_GAIN, 16'd0);
        repeat (WINDUP_UP) send_request(FULL_FWD, 1'b0, '0);
        repeat (WINDUP_DOWN) send_request(FULL_REV, 1'b0, '0);

        // Random requests under a series of gain settings.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_gain(pmd_pkg::CFG_P_GAIN, pmd_pkg::P_GAIN_RST);
                    write_gain(pmd_pkg::CFG_I_GAIN, pmd_pkg::I_GAIN_RST);
                    write_gain(pmd_pkg::CFG_D_GAIN, pmd_pkg::D_GAIN_RST);
                end
                1: begin
                    write_gain(pmd_pkg::CFG_P_GAIN, 16'd0);
                    write_gain(pmd_pkg::CFG_I_GAIN, 16'd0);
                end
                2: begin
                    write_gain(pmd_pkg::CFG_P_GAIN, 16'hFFFF);
                    write_gain(pmd_pkg::CFG_I_GAIN, 16'hFFFF);
                    write_gain(pmd_pkg::CFG_D_GAIN, 16'hFFFF);
                end
                3: begin
                    write_gain(pmd_pkg::CFG_I_GAIN, 16'd0);
                    write_gain(pmd_pkg::CFG_D_GAIN, 16'd0);
                end
                4: begin
                    write_gain(pmd_pkg::CFG_P_GAIN, 16'd0);
                    write_gain(pmd_pkg::CFG_I_GAIN, 16'hFFFF);
                end
                5: begin
                    write_gain(pmd_pkg::CFG_I_GAIN, 16'd0);
                    write_gain(pmd_pkg::CFG_D_GAIN, 16'hFFFF);
                end
                6: begin
                    write_gain(pmd_pkg::CFG_P_GAIN, 16'($urandom));
                    write_gain(pmd_pkg::CFG_I_GAIN, 16'($urandom));
                    write_gain(pmd_pkg::CFG_D_GAIN, 16'($urandom));
                end
                default: begin
                    write_gain(pmd_pkg::CFG_P_GAIN, 16'($urandom_range(0, 4096)));
                    write_gain(pmd_pkg::CFG_I_GAIN, 16'($urandom_range(0, 4096)));
                    write_gain(pmd_pkg::CFG_D_GAIN, 16'($urandom_range(0, 64)));
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                calm = (phase == NUM_PHASES - 1) && (k >= PHASE_ITEMS - CALM_ITEMS);
                if (!calm && $urandom_range(0, 149) == 0) begin
                    drain_results();
                end
                send_request(random_request(), 1'b0, '0);
            end
        end

        // Wait for the last results, then let the pipeline settle.
        in_valid <= 1'b0;
        for (guard = 0; guard < END_WAIT && drive_queue.size() > 0; guard++) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (drive_queue.size() > 0) begin
            report_mismatch("leftover expectation count", drive_queue.size(), 0);
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[pid_motor_drive.f]
rtl/core/pmd_pkg.sv
rtl/core/pmd_integrator.sv
rtl/core/pid_motor_drive.sv
tb/sv/tb.sv
